// File: hw/rtl/kbq_pkg.sv
// Shared types and constants of the braille keypad event queue.
package kbq_pkg;

    // Report status codes carried by a read request.
    localparam logic [1:0] REP_TERR  = 2'd0;
    localparam logic [1:0] REP_SHORT = 2'd1;
    localparam logic [1:0] REP_FULL  = 2'd2;

    // Result status codes.
    localparam logic [1:0] RSP_NONE  = 2'd0;
    localparam logic [1:0] RSP_EVENT = 2'd1;
    localparam logic [1:0] RSP_TERR  = 2'd2;

    // Event kinds.
    localparam logic [1:0] KIND_CHORD  = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;

    localparam logic [7:0] DISPLAY_CELLS_RESET = 8'd44;
    localparam int CMD_IDX_W = 3;

    // One queued event as it sits in the event store.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_event;

    // Events that one decoded report still has to push, in push order.
    typedef struct packed {
        logic       chord_pend;
        logic [7:0] chord_val;
        logic [7:0] cmd_mask;
        logic       cur_pend;
        logic [7:0] cur_val;
    } t_push_set;

endpackage

// File: hw/rtl/kbq_if.sv
// Valid/ready channel interfaces for read requests and results.
interface kbq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] report_status;
    logic [7:0] chord_byte;
    logic [7:0] function_byte;
    logic [7:0] cursor_byte;

    modport source (output valid, report_status, chord_byte, function_byte, cursor_byte,
                    input ready);
    modport sink (input valid, report_status, chord_byte, function_byte, cursor_byte,
                  output ready);
endinterface

interface kbq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_status;
    logic [1:0] event_kind;
    logic [7:0] event_value;
    logic       report_consumed;

    modport source (output valid, result_status, event_kind, event_value, report_consumed,
                    input ready);
    modport sink (input valid, result_status, event_kind, event_value, report_consumed,
                  output ready);
endinterface

// File: hw/rtl/kbq_ram.sv
// Event store: one write port and one read port with registered read data.
module kbq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  kbq_pkg::t_event i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output kbq_pkg::t_event o_rd_data
);
    import kbq_pkg::*;

    t_event r_mem [DEPTH];
    t_event r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/kbq_decode.sv
// Key report decoder: holds the previous key state and lists the events to push.
module kbq_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_strobe,
    input  logic [7:0]         i_chord,
    input  logic [7:0]         i_func,
    input  logic [7:0]         i_cursor,
    input  logic [7:0]         i_display_cells,
    output kbq_pkg::t_push_set o_set
);
    import kbq_pkg::*;

    logic [7:0] r_latched_chord;
    logic [7:0] r_prev_func;
    logic [7:0] r_prev_cursor;
    logic [7:0] n_latched_chord;
    logic       chord_push;

    always_comb begin
        n_latched_chord = r_latched_chord;
        chord_push      = 1'b0;
        if (i_chord != r_latched_chord) begin
            if (r_latched_chord == 8'd0) begin
                n_latched_chord = i_chord;
            end else if (i_chord == 8'd0) begin
                // Full release queues the chord that was held.
                chord_push      = 1'b1;
                n_latched_chord = 8'd0;
            end else if (((r_latched_chord ^ i_chord) & i_chord) != 8'd0) begin
                n_latched_chord = i_chord;
            end
        end
    end

    always_comb begin
        o_set.chord_pend = chord_push;
        o_set.chord_val  = r_latched_chord;
        o_set.cmd_mask   = i_func & ~r_prev_func;
        o_set.cur_pend   = (i_cursor != r_prev_cursor) && (i_cursor != 8'd0)
                           && (i_cursor <= i_display_cells);
        o_set.cur_val    = i_cursor - 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched_chord <= 8'd0;
            r_prev_func     <= 8'd0;
            r_prev_cursor   <= 8'd0;
        end else if (i_strobe) begin
            r_latched_chord <= n_latched_chord;
            r_prev_func     <= i_func;
            r_prev_cursor   <= i_cursor;
        end
    end

endmodule

// File: hw/rtl/braille_keypad_event_queue_unit.sv
// A request that meets a non-empty queue pops the head: the store read is registered and
// the result register loads in S_DATA. A decoded report first queues its N events (0 to 10),
// one store write per cycle in S_PUSH, then pops the head if any; other requests on an
// empty queue go straight to S_DATA. Requests are taken only in S_IDLE, after the result loads.
// Reset (synchronous, active low) empties the queue, clears the key state and sets
// display_cells to 44; store contents are not cleared and need no clearing pass.
module braille_keypad_event_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    kbq_req_if.sink    i_req,
    kbq_rsp_if.source  o_rsp
);
    import kbq_pkg::*;

    // Pointer width of the ring. The count never exceeds QUEUE_DEPTH-1, so it fits too.
    localparam int             PW      = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0]  LAST    = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW:0]    DEPTH_W = (PW + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_DATA
    } t_state;

    t_state     r_state;
    logic [7:0] r_display_cells;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_count;
    t_push_set  r_push;
    logic       r_pop;
    logic [1:0] r_status;
    logic       r_consumed;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_value;
    logic       r_out_consumed;

    logic       accept;
    logic       dec_strobe;
    t_push_set  dec_set;
    logic       have_push;
    logic [CMD_IDX_W-1:0] cmd_idx;
    logic [PW-1:0] head_nxt;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot;
    logic       wr_en;
    t_event     wr_data;
    t_push_set  n_push;
    logic       rd_en;
    t_event     rd_data;
    logic       out_load;

    // Requests are taken only between items; a finished result may still sit in the
    // output register while the next request transfers.
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);

    // The report is decoded only when the queue is empty and the report is complete.
    assign dec_strobe  = accept && (r_count == '0) && (i_req.report_status == REP_FULL);

    kbq_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_strobe        (dec_strobe),
        .i_chord         (i_req.chord_byte),
        .i_func          (i_req.function_byte),
        .i_cursor        (i_req.cursor_byte),
        .i_display_cells (r_display_cells),
        .o_set           (dec_set)
    );

    // Ring arithmetic: the head wraps at the last entry, and the tail slot is the head
    // plus the count, folded back once since the sum stays below twice the depth.
    assign head_nxt = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign slot_sum = {1'b0, r_head} + {1'b0, r_count};
    assign slot     = (slot_sum >= DEPTH_W) ? PW'(slot_sum - DEPTH_W) : slot_sum[PW-1:0];

    // Command codes are pushed from the lowest rising bit upward.
    always_comb begin
        cmd_idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_push.cmd_mask[i]) begin
                cmd_idx = CMD_IDX_W'(i);
            end
        end
    end

    assign have_push = r_push.chord_pend || (r_push.cmd_mask != 8'd0) || r_push.cur_pend;

    // Select the next pending event in model order: chord, commands, then cursor.
    always_comb begin
        n_push  = r_push;
        wr_data = '0;
        if (r_push.chord_pend) begin
            wr_data.kind      = KIND_CHORD;
            wr_data.value     = r_push.chord_val;
            n_push.chord_pend = 1'b0;
        end else if (r_push.cmd_mask != 8'd0) begin
            wr_data.kind    = KIND_CMD;
            wr_data.value   = {5'd0, cmd_idx};
            n_push.cmd_mask = r_push.cmd_mask & (r_push.cmd_mask - 8'd1);
        end else begin
            wr_data.kind    = KIND_CURSOR;
            wr_data.value   = r_push.cur_val;
            n_push.cur_pend = 1'b0;
        end
    end

    assign wr_en = (r_state == S_PUSH) && have_push;

    // The head entry is read only in a cycle with no store write, so a pop never races
    // a push into the same entry.
    assign rd_en = (r_count != '0)
                   && ((accept) || ((r_state == S_PUSH) && !have_push));

    // The result register loads once the previous result has left or is leaving.
    assign out_load = (r_state == S_DATA) && (!r_out_valid || o_rsp.ready);

    kbq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_display_cells <= DISPLAY_CELLS_RESET;
            r_head          <= '0;
            r_count         <= '0;
            r_push          <= '0;
            r_pop           <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_display_cells <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_count != '0) begin
                            // Queue not empty: the report is ignored and the head pops.
                            r_consumed <= 1'b0;
                            r_status   <= RSP_NONE;
                            r_pop      <= 1'b1;
                            r_head     <= head_nxt;
                            r_count    <= r_count - 1'b1;
                            r_state    <= S_DATA;
                        end else if (i_req.report_status == REP_FULL) begin
                            r_consumed <= 1'b1;
                            r_status   <= RSP_NONE;
                            r_pop      <= 1'b0;
                            r_push     <= dec_set;
                            r_state    <= S_PUSH;
                        end else begin
                            r_consumed <= 1'b0;
                            r_pop      <= 1'b0;
                            r_status   <= (i_req.report_status == REP_TERR) ? RSP_TERR
                                                                             : RSP_NONE;
                            r_state    <= S_DATA;
                        end
                    end
                end
                S_PUSH: begin
                    if (have_push) begin
                        r_push <= n_push;
                        // A full ring drops its oldest entry on a push.
                        if (r_count == LAST) begin
                            r_head <= head_nxt;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end else begin
                        if (r_count != '0) begin
                            r_pop   <= 1'b1;
                            r_head  <= head_nxt;
                            r_count <= r_count - 1'b1;
                        end
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (out_load) begin
                        r_out_status   <= r_pop ? RSP_EVENT : r_status;
                        r_out_kind     <= r_pop ? rd_data.kind : 2'd0;
                        r_out_value    <= r_pop ? rd_data.value : 8'd0;
                        r_out_consumed <= r_consumed;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.result_status   = r_out_status;
    assign o_rsp.event_kind      = r_out_kind;
    assign o_rsp.event_value     = r_out_value;
    assign o_rsp.report_consumed = r_out_consumed;

`ifndef SYNTHESIS
    // A request that meets a non-empty queue always pops and goes straight to the result.
    a_busy_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_count != '0)) |=> (r_pop && (r_state == S_DATA)))
        else $error("request on a non-empty queue did not pop");

    // The store is never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("store read and write overlap");

    // A transport error result carries no event and no decoded report.
    a_terr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == RSP_TERR))
        |-> (!r_out_consumed && (r_out_value == 8'd0) && (r_out_kind == 2'd0)))
        else $error("transport error result carries data");
`endif

endmodule
